@@ src/buddy_block_allocate_macros.svh @@
// Assertion macros used by the checker file.
// Both sample on the rising clock and are muted while reset is high.
`ifndef BUDDY_BLOCK_ALLOCATE_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, defaults and helpers of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int ORDER_W         = 5;   // req_order and max_order width
   localparam int TOP_LEFT_W      = 5;   // top_blocks_left width
   localparam int MAX_ORDER_RST   = 12;
   localparam int LEVELS_DEF      = 21;
   localparam int STACK_DEPTH_DEF = 64;
   localparam int TOP_BLOCKS_DEF  = 16;
   localparam int OFFSET_BITS_DEF = 20;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_READ,
      ST_SPLIT,
      ST_DONE
   } bba_state_type;

   typedef enum logic {
      STEP_UP,
      STEP_DOWN
   } bba_step_type;

   typedef struct packed {
      logic pop;
      logic push;
   } bba_stk_op_type;

   // order actually used as top level
   function automatic int top_of(input int order, input int levels);
      return (order >= levels) ? levels - 1 : order;
   endfunction

   function automatic int min_of(input int a, input int b);
      return (a < b) ? a : b;
   endfunction

endpackage

@@ src/bba_if.sv @@
// ----------------------------------------------------------------------------
// bba channel interfaces
// Valid/ready channels for requests, responses and the max_order register.
// ----------------------------------------------------------------------------
interface bba_req_if import bba_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ORDER_W-1:0] req_order;

   modport source (output valid, req_order, input ready);
   modport sink   (input valid, req_order, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic                  granted;
   logic [OFFSET_BITS-1:0] block_offset;
   logic [TOP_LEFT_W-1:0] top_blocks_left;

   modport source (output valid, granted, block_offset, top_blocks_left, input ready);
   modport sink   (input valid, granted, block_offset, top_blocks_left, output ready);
endinterface

interface bba_csr_if import bba_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ORDER_W-1:0] max_order;

   modport source (output valid, max_order, input ready);
   modport sink   (input valid, max_order, output ready);
endinterface

@@ src/buddy_block_allocate.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocate
// Buddy allocator, allocation side: pops a free block of the requested order
// or larger and splits it down, pushing the upper buddies.
// ----------------------------------------------------------------------------
//  channel    dir  handshake     payload
//  req_chan   in   valid/ready   req_order
//  rsp_chan   out  valid/ready   granted, block_offset, top_blocks_left
//  csr_chan   in   valid/ready   max_order (reformats the zone)
//
//  One item at a time. With L the level where a free block is found and R
//  the requested order, an item passes through accept, search from R up to
//  L, one read (not at top), split from L down to R and handoff; stack
//  memory has one port, so levels are visited one at a time. A request
//  above the top order goes from accept straight to handoff. Reset and a
//  csr write restore the zone. A stalled response holds in its register;
//  the next item is taken meanwhile.
module buddy_block_allocate import bba_pkg::*; #(
   parameter int LEVELS      = LEVELS_DEF,
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int TOP_BLOCKS  = TOP_BLOCKS_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bba_req_if.sink   req_chan,
   bba_rsp_if.source rsp_chan,
   bba_csr_if.sink   csr_chan
);

   localparam int LW  = $clog2(LEVELS);
   localparam int LVW = $clog2(LEVELS + 1);
   localparam int FW  = $clog2(STACK_DEPTH + 1);

   logic                   stk_fmt;
   logic [LW-1:0]          stk_fmt_top;
   bba_stk_op_type         stk_op;
   logic [LW-1:0]          stk_lvl;
   logic [OFFSET_BITS-1:0] stk_wr_data;
   logic [FW-1:0]          stk_fill;
   logic [OFFSET_BITS-1:0] stk_rd_data;
   bba_step_type           step_mode;
   logic [LVW-1:0]         step_lvl;
   logic [OFFSET_BITS-1:0] step_off;
   logic [LVW-1:0]         step_lvl_nx;
   logic [OFFSET_BITS-1:0] step_buddy;

   bba_ctrl #(
      .LEVELS      (LEVELS),
      .STACK_DEPTH (STACK_DEPTH),
      .TOP_BLOCKS  (TOP_BLOCKS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_chan    (csr_chan),
      .stk_fmt     (stk_fmt),
      .stk_fmt_top (stk_fmt_top),
      .stk_op      (stk_op),
      .stk_lvl     (stk_lvl),
      .stk_wr_data (stk_wr_data),
      .stk_fill    (stk_fill),
      .stk_rd_data (stk_rd_data),
      .step_mode   (step_mode),
      .step_lvl    (step_lvl),
      .step_off    (step_off),
      .step_lvl_nx (step_lvl_nx),
      .step_buddy  (step_buddy)
   );

   bba_stack #(
      .LEVELS      (LEVELS),
      .STACK_DEPTH (STACK_DEPTH),
      .TOP_BLOCKS  (TOP_BLOCKS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_stack (
      .clock   (clock),
      .reset   (reset),
      .fmt     (stk_fmt),
      .fmt_top (stk_fmt_top),
      .op      (stk_op),
      .lvl     (stk_lvl),
      .wr_data (stk_wr_data),
      .fill    (stk_fill),
      .rd_data (stk_rd_data)
   );

   bba_step #(
      .LVW         (LVW),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_step (
      .mode   (step_mode),
      .lvl    (step_lvl),
      .off    (step_off),
      .lvl_nx (step_lvl_nx),
      .buddy  (step_buddy)
   );

endmodule

@@ src/bba_step.sv @@
// ----------------------------------------------------------------------------
// bba_step
// Shared level step unit: moves the level up or down by one and forms the
// upper buddy offset at the new level.
// ----------------------------------------------------------------------------
module bba_step import bba_pkg::*; #(
   parameter int LVW         = 5,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  bba_step_type           mode,
   input  logic [LVW-1:0]         lvl,
   input  logic [OFFSET_BITS-1:0] off,
   output logic [LVW-1:0]         lvl_nx,
   output logic [OFFSET_BITS-1:0] buddy
);

   always_comb begin
      lvl_nx = (mode == STEP_UP) ? lvl + LVW'(1) : lvl - LVW'(1);
      // bits shifted past the offset width drop out, as the offset wraps
      buddy  = off + (OFFSET_BITS'(1) << lvl_nx);
   end

endmodule

@@ src/bba_stack.sv @@
// ----------------------------------------------------------------------------
// bba_stack
// Per-level free stacks: fill counters in flops, entries in one memory.
// The top level is never pushed, so its entries are implied by its fill.
// ----------------------------------------------------------------------------
module bba_stack import bba_pkg::*; #(
   parameter int LEVELS      = LEVELS_DEF,
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int TOP_BLOCKS  = TOP_BLOCKS_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF,
   localparam int LW         = $clog2(LEVELS),
   localparam int FW         = $clog2(STACK_DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fmt,
   input  logic [LW-1:0]          fmt_top,
   input  bba_stk_op_type         op,
   input  logic [LW-1:0]          lvl,
   input  logic [OFFSET_BITS-1:0] wr_data,
   output logic [FW-1:0]          fill,
   output logic [OFFSET_BITS-1:0] rd_data
);

   localparam int IW        = $clog2(STACK_DEPTH);
   localparam int MEM_DEPTH = LEVELS << IW;
   localparam int N_INIT    = min_of(TOP_BLOCKS, STACK_DEPTH);
   localparam int TOP_RST   = top_of(MAX_ORDER_RST, LEVELS);

   logic [FW-1:0]          fill_ff [LEVELS];
   logic [FW-1:0]          fill_in [LEVELS];
   logic [OFFSET_BITS-1:0] mem     [MEM_DEPTH];
   logic [OFFSET_BITS-1:0] rd_data_ff;
   logic                   not_full;

   assign fill     = fill_ff[lvl];
   assign not_full = (fill < FW'(STACK_DEPTH));
   assign rd_data  = rd_data_ff;

   always_comb begin
      fill_in = fill_ff;
      if (fmt) begin
         for (int i = 0; i < LEVELS; i++) begin
            fill_in[i] = (LW'(i) == fmt_top) ? FW'(N_INIT) : '0;
         end
      end else if (op.pop) begin
         fill_in[lvl] = fill - FW'(1);
      end else if (op.push && not_full) begin
         fill_in[lvl] = fill + FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            fill_ff[i] <= (i == TOP_RST) ? FW'(N_INIT) : '0;
         end
      end else begin
         fill_ff <= fill_in;
      end
   end

   // push onto a full stack drops the buddy
   always_ff @(posedge clock) begin
      if (op.push && not_full) begin
         mem[{lvl, IW'(fill)}] <= wr_data;
      end
      if (op.pop) begin
         rd_data_ff <= mem[{lvl, IW'(fill - FW'(1))}];
      end
   end

endmodule

@@ src/bba_ctrl.sv @@
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: search up for a non-empty stack, pop, split down to the
// requested order, then hand the item to the response register.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; #(
   parameter int LEVELS      = LEVELS_DEF,
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int TOP_BLOCKS  = TOP_BLOCKS_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF,
   localparam int LW         = $clog2(LEVELS),
   localparam int LVW        = $clog2(LEVELS + 1),
   localparam int FW         = $clog2(STACK_DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   bba_req_if.sink                req_chan,
   bba_rsp_if.source              rsp_chan,
   bba_csr_if.sink                csr_chan,
   // stack side
   output logic                   stk_fmt,
   output logic [LW-1:0]          stk_fmt_top,
   output bba_stk_op_type         stk_op,
   output logic [LW-1:0]          stk_lvl,
   output logic [OFFSET_BITS-1:0] stk_wr_data,
   input  logic [FW-1:0]          stk_fill,
   input  logic [OFFSET_BITS-1:0] stk_rd_data,
   // step unit side
   output bba_step_type           step_mode,
   output logic [LVW-1:0]         step_lvl,
   output logic [OFFSET_BITS-1:0] step_off,
   input  logic [LVW-1:0]         step_lvl_nx,
   input  logic [OFFSET_BITS-1:0] step_buddy
);

   localparam int TCW     = $clog2(TOP_BLOCKS + 1);
   localparam int N_INIT  = min_of(TOP_BLOCKS, STACK_DEPTH);
   localparam int TOP_RST = top_of(MAX_ORDER_RST, LEVELS);

   bba_state_type           state_ff, state_in;
   logic [LW-1:0]           top_ff, top_in;
   logic [ORDER_W-1:0]      req_ff, req_in;
   logic [LVW-1:0]          lvl_ff, lvl_in;
   logic [OFFSET_BITS-1:0]  off_ff, off_in;
   logic                    grant_ff, grant_in;
   logic [TCW-1:0]          top_cnt_ff, top_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_granted_ff, rsp_granted_in;
   logic [OFFSET_BITS-1:0]  rsp_off_ff, rsp_off_in;
   logic [TOP_LEFT_W-1:0]   rsp_left_ff, rsp_left_in;

   logic                    csr_acc, req_acc, req_too_big;
   logic                    at_top, at_req, empty, slot_free;
   logic [LW-1:0]           csr_top;
   logic [FW-1:0]           top_idx;
   logic [OFFSET_BITS-1:0]  top_off;

   assign csr_acc     = csr_chan.valid && csr_chan.ready;
   assign req_acc     = req_chan.valid && req_chan.ready;
   assign req_too_big = (req_chan.req_order > ORDER_W'(top_ff));
   assign at_top      = (lvl_ff == LVW'(top_ff));
   assign at_req      = (lvl_ff == LVW'(req_ff));
   assign empty       = (stk_fill == '0);
   assign slot_free   = !rsp_valid_ff || rsp_chan.ready;
   assign csr_top     = (int'(csr_chan.max_order) >= LEVELS) ? LW'(LEVELS - 1)
                                                             : LW'(csr_chan.max_order);
   // top stack holds offsets (N_INIT-1-idx) << top, idx the slot being popped
   assign top_idx     = FW'(N_INIT - 1) - (stk_fill - FW'(1));
   assign top_off     = OFFSET_BITS'(top_idx) << top_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = req_too_big ? ST_DONE : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (empty) begin
               state_in = at_top ? ST_DONE : ST_SEARCH;
            end else begin
               state_in = at_top ? ST_SPLIT : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            if (at_req) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      csr_chan.ready = (state_ff == ST_IDLE);
      req_chan.ready = (state_ff == ST_IDLE) && !csr_chan.valid;
      stk_fmt        = csr_acc;
      stk_fmt_top    = csr_top;
      stk_op         = '0;
      stk_wr_data    = step_buddy;
      step_mode      = STEP_UP;
      step_lvl       = lvl_ff;
      step_off       = off_ff;
      stk_lvl        = lvl_ff[LW-1:0];
      unique case (state_ff)
         ST_SEARCH: begin
            stk_op.pop = !empty;
         end
         ST_SPLIT: begin
            step_mode   = STEP_DOWN;
            stk_lvl     = step_lvl_nx[LW-1:0];
            stk_op.push = !at_req;
         end
         ST_IDLE, ST_READ, ST_DONE: begin
            stk_op = '0;
         end
         default: begin
            stk_op = '0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      top_in         = top_ff;
      req_in         = req_ff;
      lvl_in         = lvl_ff;
      off_in         = off_ff;
      grant_in       = grant_ff;
      top_cnt_in     = top_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_off_in     = rsp_off_ff;
      rsp_left_in    = rsp_left_ff;
      case (state_ff)
         ST_IDLE: begin
            if (csr_acc) begin
               top_in     = csr_top;
               top_cnt_in = TCW'(TOP_BLOCKS);
            end else if (req_acc) begin
               req_in   = req_chan.req_order;
               lvl_in   = LVW'(req_chan.req_order);
               off_in   = '0;
               grant_in = 1'b0;
            end
         end
         ST_SEARCH: begin
            if (empty) begin
               if (!at_top) begin
                  lvl_in = step_lvl_nx;
               end
            end else begin
               grant_in = 1'b1;
               if (at_top) begin
                  off_in = top_off;
                  if (top_cnt_ff != '0) begin
                     top_cnt_in = top_cnt_ff - TCW'(1);
                  end
               end
            end
         end
         ST_READ: begin
            off_in = stk_rd_data;
         end
         ST_SPLIT: begin
            if (!at_req) begin
               lvl_in = step_lvl_nx;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = grant_ff;
               rsp_off_in     = off_ff;
               rsp_left_in    = TOP_LEFT_W'(top_cnt_ff);
            end
         end
         default: begin
            lvl_in = lvl_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         top_ff       <= LW'(TOP_RST);
         top_cnt_ff   <= TCW'(TOP_BLOCKS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         top_cnt_ff   <= top_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      lvl_ff         <= lvl_in;
      off_ff         <= off_in;
      grant_ff       <= grant_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_off_ff     <= rsp_off_in;
      rsp_left_ff    <= rsp_left_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.granted         = rsp_granted_ff;
   assign rsp_chan.block_offset    = rsp_off_ff;
   assign rsp_chan.top_blocks_left = rsp_left_ff;

endmodule

@@ src/bba_checker.sv @@
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "buddy_block_allocate_macros.svh"

module bba_checker import bba_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_granted,
   input logic [OFFSET_BITS-1:0] rsp_block_offset,
   input logic                   csr_valid,
   input logic                   csr_ready
);

   `BBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `BBA_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready right after an item")
   `BBA_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp_granted, rsp_block_offset == '0, "failed item with offset")
   `BBA_ASSERT_NOW(a_csr_vs_req, csr_valid && csr_ready, !(req_valid && req_ready), "csr write with item")

endmodule

bind buddy_block_allocate bba_checker #(
   .OFFSET_BITS (OFFSET_BITS)
) u_bba_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_granted      (rsp_chan.granted),
   .rsp_block_offset (rsp_chan.block_offset),
   .csr_valid        (csr_chan.valid),
   .csr_ready        (csr_chan.ready)
);
